/* sv/tcs_pkg.sv */
// shared constants and types for the text console with scrollback
`default_nettype none
package tcs_pkg;
  localparam int HIST_LINES = 1024;
  localparam int COL_LIMIT  = 128;
  localparam int ROW_LIMIT  = 64;
  localparam int SLOT_W     = $clog2(HIST_LINES);
  localparam int COL_W      = $clog2(COL_LIMIT);
  localparam int ADDR_W     = SLOT_W + COL_W;
  localparam int MEM_DEPTH  = HIST_LINES * COL_LIMIT;

  localparam logic [7:0] COL_MIN = 8'd40;
  localparam logic [7:0] COL_MAX = 8'(COL_LIMIT);
  localparam logic [6:0] ROW_MIN = 7'd10;
  localparam logic [6:0] ROW_MAX = 7'(ROW_LIMIT);

  localparam logic [15:0] BLANK_CELL  = 16'h0720;
  localparam logic [15:0] HANDLE_CELL = 16'h0FDB;
  localparam logic [15:0] TRACK_CELL  = 16'h08B3;
  localparam logic [7:0]  CH_BS       = 8'h08;
  localparam logic [7:0]  CH_NL       = 8'h0A;
  localparam logic [7:0]  CH_SPACE    = 8'h20;
  localparam logic [31:0] LINES_SAT   = 32'hFFFF_FFFF;

  localparam logic [2:0] OP_PUT  = 3'd0;
  localparam logic [2:0] OP_SUP  = 3'd1;
  localparam logic [2:0] OP_SDN  = 3'd2;
  localparam logic [2:0] OP_CLR  = 3'd3;
  localparam logic [2:0] OP_READ = 3'd4;

  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;
  localparam logic [1:0] CFG_ATTR    = 2'd2;

  localparam int DIV_NUM_W = 16;
  localparam int DIV_DEN_W = 32;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b0_0000_0001,
    ST_CLEAR = 9'b0_0000_0010,
    ST_BLANK = 9'b0_0000_0100,
    ST_PUTW  = 9'b0_0000_1000,
    ST_RA    = 9'b0_0001_0000,
    ST_RB    = 9'b0_0010_0000,
    ST_RD    = 9'b0_0100_0000,
    ST_DIV   = 9'b0_1000_0000,
    ST_DONE  = 9'b1_0000_0000
  } state_t;
endpackage
`default_nettype wire

/* sv/text_console_scrollback.sv */
// text console with circular scrollback store, top level
//
//  channel | ports                                          | handshake
//  in      | in_opcode in_char_code in_view_row in_view_col | in_valid / in_stall
//  out     | out_cell_res out_cursor_pos out_cursor_hidden   | out_valid / out_stall
//  cfg     | cfg_idx cfg_wdata                              | cfg_we, no wait
//
// one item at a time; a scrollbar read runs the 16-step serial divider, and a newline
// or wrap blanks the new line one cell a cycle through the ram port.
// after reset a pass writes blanks over all 131072 ram cells, and for a clear item
// over the cells below eff_columns in every line, one address a cycle, with in_stall
// high; a clear item answers after it. in_stall drops again once a result is in the
// output register, or when the reset pass ends.
`default_nettype none
module text_console_scrollback
  import tcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [5:0]  in_view_row,
  input  wire logic [6:0]  in_view_col,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_cell_res,
  output logic [12:0]      out_cursor_pos,
  output logic             out_cursor_hidden,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [7:0]  cfg_wdata
);
  state_t              state_r, state_nxt;
  logic [7:0]          cols_r, attr_r;
  logic [6:0]          rows_r;
  logic [31:0]         lt_r, lt_nxt;
  logic [COL_W-1:0]    wc_r, wc_nxt;
  logic [SLOT_W-1:0]   vo_r, vo_nxt;
  logic [ADDR_W-1:0]   sweep_r, sweep_nxt;
  logic                clr_all_r, clr_all_nxt;
  logic                clr_res_r, clr_res_nxt;
  logic                pend_r, pend_nxt;
  logic [7:0]          ch_r, ch_nxt;
  logic [COL_W-1:0]    bcol_r, bcol_nxt;
  logic [5:0]          row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [31:0]         start_r, start_nxt;
  logic [15:0]         cell_r, cell_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [15:0]         out_cell_r;
  logic [12:0]         out_pos_r;
  logic                out_hid_r;

  logic [7:0]          eff_cols;
  logic [6:0]          eff_rows, vis, vism1, crow;
  logic [31:0]         scroll_lim;
  logic                can_scroll;
  logic signed [33:0]  start_diff;
  logic [32:0]         idx;
  logic [14:0]         pos_full;
  logic [SLOT_W-1:0]   slot;
  logic                load_out;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [15:0]         ram_wdata, ram_rdata;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  always_comb begin
    priority if (cols_r < COL_MIN) eff_cols = COL_MIN;
    else if (cols_r > COL_MAX)     eff_cols = COL_MAX;
    else                           eff_cols = cols_r;
    priority if (rows_r < ROW_MIN) eff_rows = ROW_MIN;
    else if (rows_r > ROW_MAX)     eff_rows = ROW_MAX;
    else                           eff_rows = rows_r;
  end

  assign vis        = eff_rows - 7'd2;
  assign vism1      = eff_rows - 7'd3;
  assign scroll_lim = (lt_r > {25'd0, vism1}) ? (lt_r - {25'd0, vism1}) : 32'd0;
  assign can_scroll = ({22'd0, vo_r} < scroll_lim) &&
                      (({1'b0, vo_r} + 11'(vis)) < 11'(HIST_LINES));
  assign start_diff = $signed({2'b00, lt_r}) - $signed({24'd0, vo_r})
                      - $signed({27'd0, vism1});
  assign idx        = {1'b0, start_r} + {27'd0, row_r};
  assign slot       = lt_r[SLOT_W-1:0];
  assign crow       = (lt_r > {25'd0, vism1}) ? vism1 : lt_r[6:0];
  assign pos_full   = crow * eff_cols + {8'd0, wc_r};
  assign load_out   = state_r == ST_DONE && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt   = state_r;
    lt_nxt      = lt_r;
    wc_nxt      = wc_r;
    vo_nxt      = vo_r;
    sweep_nxt   = sweep_r;
    clr_all_nxt = clr_all_r;
    clr_res_nxt = clr_res_r;
    pend_nxt    = pend_r;
    ch_nxt      = ch_r;
    bcol_nxt    = bcol_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    start_nxt   = start_r;
    cell_nxt    = cell_r;
    ram_we      = 1'b0;
    ram_waddr   = {slot, wc_r};
    ram_wdata   = BLANK_CELL;
    ram_re      = 1'b0;
    ram_raddr   = {idx[SLOT_W-1:0], col_r};
    div_req.start    = 1'b0;
    div_req.dividend = 16'({6'd0, vo_r} * {9'd0, vism1});
    div_req.divisor  = scroll_lim;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cell_nxt  = '0;
          state_nxt = ST_DONE;
          priority case (in_opcode)
            OP_PUT: begin
              vo_nxt = '0;
              priority if (in_char_code == CH_BS) begin
                if (wc_r != '0) begin
                  wc_nxt    = wc_r - 1'b1;
                  ram_we    = 1'b1;
                  ram_waddr = {slot, wc_r - 1'b1};
                  ram_wdata = {attr_r, CH_SPACE};
                end
              end else if (in_char_code == CH_NL ||
                           {1'b0, wc_r} >= eff_cols - 8'd1) begin
                // newline, or wrap before writing any other character
                wc_nxt    = '0;
                if (lt_r != LINES_SAT) lt_nxt = lt_r + 32'd1;
                bcol_nxt  = '0;
                pend_nxt  = in_char_code != CH_NL;
                ch_nxt    = in_char_code;
                state_nxt = ST_BLANK;
              end else begin
                wc_nxt    = wc_r + 1'b1;
                ram_we    = 1'b1;
                ram_wdata = {attr_r, in_char_code};
              end
            end
            OP_SUP: begin
              if (can_scroll) vo_nxt = vo_r + 1'b1;
            end
            OP_SDN: begin
              if (vo_r != '0) vo_nxt = vo_r - 1'b1;
            end
            OP_CLR: begin
              sweep_nxt   = '0;
              clr_all_nxt = 1'b0;
              clr_res_nxt = 1'b1;
              state_nxt   = ST_CLEAR;
            end
            OP_READ: begin
              row_nxt   = in_view_row;
              col_nxt   = in_view_col;
              state_nxt = ST_RA;
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        ram_we    = clr_all_r || ({1'b0, sweep_r[COL_W-1:0]} < eff_cols);
        ram_waddr = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == '1) begin
          lt_nxt    = '0;
          wc_nxt    = '0;
          vo_nxt    = '0;
          state_nxt = clr_res_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = {slot, bcol_r};
        bcol_nxt  = bcol_r + 1'b1;
        if ({1'b0, bcol_r} == eff_cols - 8'd1) begin
          state_nxt = pend_r ? ST_PUTW : ST_DONE;
        end
      end
      ST_PUTW: begin
        ram_we    = 1'b1;
        ram_waddr = {slot, {COL_W{1'b0}}};
        ram_wdata = {attr_r, ch_r};
        wc_nxt    = COL_W'(1);
        state_nxt = ST_DONE;
      end
      ST_RA: begin
        state_nxt = ST_DONE;
        priority if ({1'b0, row_r} >= eff_rows || {1'b0, col_r} >= eff_cols) begin
          cell_nxt = '0;
        end else if ({1'b0, row_r} >= vis) begin
          cell_nxt = BLANK_CELL;
        end else if ({1'b0, col_r} == eff_cols - 8'd1) begin
          if (scroll_lim != '0) begin
            div_req.start = 1'b1;
            state_nxt     = ST_DIV;
          end else begin
            cell_nxt = TRACK_CELL;
          end
        end else begin
          start_nxt = start_diff[33] ? 32'd0 : start_diff[31:0];
          state_nxt = ST_RB;
        end
      end
      ST_RB: begin
        if (idx > {1'b0, lt_r}) begin
          cell_nxt  = BLANK_CELL;
          state_nxt = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cell_nxt  = ram_rdata;
        state_nxt = ST_DONE;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          // handle row is vis-1 minus the quotient
          cell_nxt  = ({11'd0, row_r} + {1'b0, div_rsp.quotient} == {10'd0, vism1})
                      ? HANDLE_CELL : TRACK_CELL;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      lt_r        <= '0;
      wc_r        <= '0;
      vo_r        <= '0;
      sweep_r     <= '0;
      clr_all_r   <= 1'b1;
      clr_res_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cols_r      <= 8'd80;
      rows_r      <= 7'd25;
      attr_r      <= 8'd7;
    end else begin
      state_r     <= state_nxt;
      lt_r        <= lt_nxt;
      wc_r        <= wc_nxt;
      vo_r        <= vo_nxt;
      sweep_r     <= sweep_nxt;
      clr_all_r   <= clr_all_nxt;
      clr_res_r   <= clr_res_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_COLUMNS: cols_r <= cfg_wdata;
          CFG_ROWS:    rows_r <= cfg_wdata[6:0];
          CFG_ATTR:    attr_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    ch_r    <= ch_nxt;
    bcol_r  <= bcol_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    start_r <= start_nxt;
    cell_r  <= cell_nxt;
    if (load_out) begin
      out_cell_r <= cell_r;
      out_pos_r  <= pos_full[12:0];
      out_hid_r  <= vo_r != '0;
    end
  end

  tcs_ram #(
    .WIDTH(16),
    .DEPTH(MEM_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tcs_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_stall          = state_r != ST_IDLE;
  assign out_valid         = out_valid_r;
  assign out_cell_res      = out_cell_r;
  assign out_cursor_pos    = out_pos_r;
  assign out_cursor_hidden = out_hid_r;
endmodule
`default_nettype wire

/* sv/tcs_ram.sv */
// generic one-write one-read ram with registered read data
`default_nettype none
module tcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* sv/tcs_div.sv */
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module tcs_div
  import tcs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DEN_W:0]   rem_sh;

  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, num_r[DIV_NUM_W-1]};
    if (req.start) begin
      rem_nxt = '0;
      num_nxt = req.dividend;
      den_nxt = req.divisor;
      quo_nxt = '0;
      cnt_nxt = CNT_W'(DIV_NUM_W);
    end else if (cnt_r != '0) begin
      num_nxt = {num_r[DIV_NUM_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = DIV_DEN_W'(rem_sh - {1'b0, den_r});
        quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DIV_DEN_W-1:0];
        quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule
`default_nettype wire

/* sv/tcs_checker.sv */
// port-level checks for the text console, bound to the top level
`default_nettype none
module tcs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_cell_res
);
  // the store is swept right after reset, so no item gets in
  a_rst_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken right after reset");

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_cell_res))
    else $error("stalled cell changed");
endmodule

bind text_console_scrollback tcs_checker u_tcs_checker (.*);
`default_nettype wire

/* sim/testbench.sv */
// testbench for the text console with scrollback: directed table, then random phases
`default_nettype none
module testbench;
  import tcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_opcode;
  logic [7:0]  in_char_code;
  logic [5:0]  in_view_row;
  logic [6:0]  in_view_col;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_cell_res;
  logic [12:0] out_cursor_pos;
  logic        out_cursor_hidden;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [7:0]  cfg_wdata;

  text_console_scrollback u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_char_code(in_char_code), .in_view_row(in_view_row), .in_view_col(in_view_col),
    .out_valid(out_valid), .out_stall(out_stall), .out_cell_res(out_cell_res),
    .out_cursor_pos(out_cursor_pos), .out_cursor_hidden(out_cursor_hidden),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  typedef struct {
    logic [15:0] cell_val;
    logic [12:0] pos;
    logic        hidden;
  } console_res_t;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  ch;
    logic [5:0]  row;
    logic [6:0]  col;
    bit          fixed;
    logic [15:0] cell_val;
  } stim_row_t;

  // console model state
  logic [15:0] hist [MEM_DEPTH];
  longint      lines_total;
  int          cur_slot, cur_col, view_off;
  logic [7:0]  reg_cols, reg_attr;
  logic [6:0]  reg_rows;

  console_res_t results_q[$];
  int errors, items_sent, results_seen, reads_sent, scrolls_sent, newlines_sent;
  int idle_cycles;
  int stall_mode, stall_cnt;

  function automatic int eff_cols();
    int c = reg_cols;
    if (c < COL_MIN) c = COL_MIN;
    if (c > COL_MAX) c = COL_MAX;
    return c;
  endfunction

  function automatic int eff_rows();
    int r = reg_rows;
    if (r < ROW_MIN) r = ROW_MIN;
    if (r > ROW_MAX) r = ROW_MAX;
    return r;
  endfunction

  function automatic void blank_line(int slot);
    int n = eff_cols();
    for (int i = 0; i < n; i++) hist[slot * COL_LIMIT + i] = BLANK_CELL;
  endfunction

  function automatic longint scroll_room();
    longint m = lines_total - (eff_rows() - 3);
    return (m < 0) ? 0 : m;
  endfunction

  function automatic void advance_line();
    cur_col = 0;
    if (lines_total != longint'(LINES_SAT)) begin
      lines_total++;
      cur_slot = int'(lines_total % HIST_LINES);
    end
    blank_line(cur_slot);
  endfunction

  function automatic logic [15:0] shown_cell(int r, int c);
    int cols = eff_cols();
    int nrows = eff_rows();
    longint vis = nrows - 2;
    longint ms, handle, first, idx;
    if (r >= nrows || c >= cols) return 16'h0;
    if (r >= vis) return BLANK_CELL;
    if (c == cols - 1) begin
      ms = scroll_room();
      if (ms > 0) begin
        handle = (vis - 1) - (longint'(view_off) * (vis - 1)) / ms;
        return (r == handle) ? HANDLE_CELL : TRACK_CELL;
      end
      return TRACK_CELL;
    end
    first = lines_total - view_off - (vis - 1);
    if (first < 0) first = 0;
    idx = first + r;
    if (idx > lines_total) return BLANK_CELL;
    return hist[int'(idx % HIST_LINES) * COL_LIMIT + c];
  endfunction

  // applies one item to the console state and returns what the block must answer
  function automatic console_res_t console_step(logic [2:0] op, logic [7:0] ch,
                                                logic [5:0] row, logic [6:0] col);
    console_res_t res;
    longint vis, crow;
    res.cell_val = 16'h0;
    vis = eff_rows() - 2;
    case (op)
      OP_PUT: begin
        if (ch == CH_BS) begin
          if (cur_col > 0) begin
            cur_col--;
            hist[cur_slot * COL_LIMIT + cur_col] = {reg_attr, CH_SPACE};
          end
        end else if (ch == CH_NL) begin
          advance_line();
        end else begin
          if (cur_col >= eff_cols() - 1) advance_line();
          hist[cur_slot * COL_LIMIT + cur_col] = {reg_attr, ch};
          cur_col++;
        end
        view_off = 0;
      end
      OP_SUP: begin
        if (view_off < scroll_room() && view_off + vis < HIST_LINES) view_off++;
      end
      OP_SDN: begin
        if (view_off > 0) view_off--;
      end
      OP_CLR: begin
        for (int i = 0; i < HIST_LINES; i++) blank_line(i);
        lines_total = 0;
        cur_slot = 0;
        cur_col = 0;
        view_off = 0;
      end
      OP_READ: res.cell_val = shown_cell(row, col);
      default: ;
    endcase
    crow = (lines_total > vis - 1) ? vis - 1 : lines_total;
    res.pos = 13'(crow * eff_cols() + cur_col);
    res.hidden = (view_off > 0);
    return res;
  endfunction

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // sender: called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic [2:0] op, logic [7:0] ch, logic [5:0] row,
                           logic [6:0] col, bit fixed, logic [15:0] exp_cell);
    console_res_t res;
    in_opcode = op;
    in_char_code = ch;
    in_view_row = row;
    in_view_col = col;
    in_valid = 1'b1;
    while (in_stall) @(negedge clk);
    @(posedge clk);
    res = console_step(op, ch, row, col);
    if (fixed && res.cell_val !== exp_cell)
      $display("%0t table cell disagrees with model: table %h model %h", $time, exp_cell,
               res.cell_val);
    if (fixed) res.cell_val = exp_cell;
    results_q.push_back(res);
    items_sent++;
    if (op == OP_READ) reads_sent++;
    if (op == OP_SUP || op == OP_SDN) scrolls_sent++;
    if (op == OP_PUT && ch == CH_NL) newlines_sent++;
    @(negedge clk);
  endtask

  task automatic pause_input(int cycles);
    in_valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (results_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_COLUMNS: reg_cols = data;
      CFG_ROWS:    reg_rows = data[6:0];
      default:     reg_attr = data;
    endcase
  endtask

  // one random item, weighted toward text with reads, scrolls, unused opcodes and, if allowed, clears mixed in
  task automatic random_item(int nl_weight, bit allow_clear);
    int pick = $urandom_range(0, 99);
    logic [7:0] ch = 8'($urandom);
    logic [5:0] row;
    logic [6:0] col;
    if ($urandom_range(0, 3) == 0) begin
      row = 6'($urandom);
      col = 7'($urandom);
    end else begin
      row = 6'($urandom_range(0, eff_rows() + 1));
      col = ($urandom_range(0, 2) == 0) ? 7'(eff_cols() - 1 - $urandom_range(0, 1))
                                        : 7'($urandom_range(0, eff_cols()));
    end
    if (pick < nl_weight) send_item(OP_PUT, CH_NL, row, col, 1'b0, 16'h0);
    else if (pick < 55) begin
      if ($urandom_range(0, 9) == 0) ch = CH_BS;
      send_item(OP_PUT, ch, row, col, 1'b0, 16'h0);
    end else if (pick < 67) send_item(OP_SUP, ch, row, col, 1'b0, 16'h0);
    else if (pick < 75) send_item(OP_SDN, ch, row, col, 1'b0, 16'h0);
    else if (pick < 97) send_item(OP_READ, ch, row, col, 1'b0, 16'h0);
    else if (pick < 99 || !allow_clear)
      send_item(3'($urandom_range(5, 7)), ch, row, col, 1'b0, 16'h0);
    else send_item(OP_CLR, ch, row, col, 1'b0, 16'h0);
  endtask

  task automatic random_phase(int count, int nl_weight, bit allow_clear);
    int burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        if ($urandom_range(0, 2) != 0) pause_input($urandom_range(1, 20));
      end
      burst--;
      random_item(nl_weight, allow_clear);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    console_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (results_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: cell %h pos %0d hidden %b", $time,
                 out_cell_res, out_cursor_pos, out_cursor_hidden);
      end else begin
        want = results_q.pop_front();
        if (out_cell_res !== want.cell_val) begin
          errors++;
          $display("%0t cell_res: expected %h got %h", $time, want.cell_val, out_cell_res);
        end
        if (out_cursor_pos !== want.pos) begin
          errors++;
          $display("%0t cursor_pos: expected %0d got %0d", $time, want.pos, out_cursor_pos);
        end
        if (out_cursor_hidden !== want.hidden) begin
          errors++;
          $display("%0t cursor_hidden: expected %b got %b", $time, want.hidden,
                   out_cursor_hidden);
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("[text_console_scrollback] ERROR");
      $finish;
    end
  end

  // receiver stall pattern: free, random, or periodic, switching now and then
  always @(negedge clk) begin
    stall_cnt++;
    if (stall_cnt % 300 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 2) == 0);
      default: out_stall = (stall_cnt % 7) < 3;
    endcase
  end

  stim_row_t dir_tbl[] = '{
    '{OP_READ, 8'h00, 6'd0,  7'd0,   1, BLANK_CELL},
    '{OP_READ, 8'h00, 6'd0,  7'd79,  1, TRACK_CELL},
    '{OP_READ, 8'h00, 6'd23, 7'd5,   1, BLANK_CELL},
    '{OP_READ, 8'h00, 6'd63, 7'd0,   1, 16'h0},
    '{OP_READ, 8'h00, 6'd0,  7'd127, 1, 16'h0},
    '{OP_READ, 8'h00, 6'd5,  7'd3,   1, BLANK_CELL},
    '{OP_PUT,  8'h41, 6'd0,  7'd0,   0, 16'h0},
    '{OP_PUT,  8'hFF, 6'd0,  7'd0,   0, 16'h0},
    '{OP_PUT,  8'h00, 6'd0,  7'd0,   0, 16'h0},
    '{OP_PUT,  CH_BS, 6'd0,  7'd0,   0, 16'h0},
    '{OP_READ, 8'h00, 6'd0,  7'd1,   0, 16'h0},
    '{OP_PUT,  CH_NL, 6'd0,  7'd0,   0, 16'h0},
    '{OP_PUT,  CH_BS, 6'd0,  7'd0,   0, 16'h0},
    '{OP_SUP,  8'h00, 6'd0,  7'd0,   0, 16'h0},
    '{OP_SDN,  8'h00, 6'd0,  7'd0,   0, 16'h0},
    '{OP_READ, 8'h00, 6'd0,  7'd0,   0, 16'h0},
    '{OP_READ, 8'h00, 6'd1,  7'd0,   0, 16'h0},
    '{3'd5,    8'hFF, 6'd63, 7'd127, 1, 16'h0},
    '{3'd6,    8'h00, 6'd0,  7'd0,   1, 16'h0},
    '{3'd7,    8'h55, 6'd42, 7'd85,  1, 16'h0},
    '{OP_CLR,  8'h00, 6'd0,  7'd0,   0, 16'h0},
    '{OP_READ, 8'h00, 6'd0,  7'd0,   1, BLANK_CELL}
  };

  initial begin
    clk = 1'b1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_PUT;
    in_char_code = 8'h0;
    in_view_row = 6'h0;
    in_view_col = 7'h0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_COLUMNS;
    cfg_wdata = 8'h0;
    errors = 0; items_sent = 0; results_seen = 0;
    reads_sent = 0; scrolls_sent = 0; newlines_sent = 0;
    idle_cycles = 0; stall_mode = 0; stall_cnt = 0;
    for (int i = 0; i < MEM_DEPTH; i++) hist[i] = BLANK_CELL;
    lines_total = 0; cur_slot = 0; cur_col = 0; view_off = 0;
    reg_cols = 8'd80; reg_rows = 7'd25; reg_attr = 8'd7;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tbl[i])
      send_item(dir_tbl[i].op, dir_tbl[i].ch, dir_tbl[i].row, dir_tbl[i].col,
                dir_tbl[i].fixed, dir_tbl[i].cell_val);
    wait_drained();

    // wide screen with long lines, then narrow so the column sits past the edge
    write_reg(CFG_COLUMNS, 8'd128);
    write_reg(CFG_ROWS, 8'd64);
    write_reg(CFG_ATTR, 8'hFF);
    random_phase(100, 2, 0);
    wait_drained();
    write_reg(CFG_COLUMNS, 8'd40);
    write_reg(CFG_ROWS, 8'd10);
    write_reg(CFG_ATTR, 8'h00);
    random_phase(100, 15, 1);
    wait_drained();
    // out-of-range register values are clamped
    write_reg(CFG_COLUMNS, 8'd0);
    write_reg(CFG_ROWS, 8'd127);
    write_reg(CFG_ATTR, 8'h5A);
    random_phase(70, 10, 0);
    wait_drained();
    write_reg(CFG_COLUMNS, 8'd255);
    write_reg(CFG_ROWS, 8'd0);
    write_reg(CFG_ATTR, 8'hA5);
    random_phase(70, 10, 0);
    wait_drained();
    // fill many lines, then scroll back up to the top limit
    write_reg(CFG_COLUMNS, 8'd40);
    write_reg(CFG_ROWS, 8'd64);
    for (int n = 0; n < 130; n++) begin
      if ($urandom_range(0, 3) == 0) random_item(0, 0);
      else send_item(OP_PUT, CH_NL, 6'($urandom), 7'($urandom), 1'b0, 16'h0);
    end
    for (int n = 0; n < 180; n++) begin
      if ($urandom_range(0, 4) == 0)
        send_item(OP_READ, 8'h0, 6'($urandom_range(0, 62)), 7'(39), 1'b0, 16'h0);
      else if ($urandom_range(0, 9) == 0)
        send_item(OP_READ, 8'h0, 6'($urandom_range(0, 62)), 7'($urandom_range(0, 39)),
                  1'b0, 16'h0);
      else send_item(OP_SUP, 8'h0, 6'h0, 7'h0, 1'b0, 16'h0);
    end
    wait_drained();
    write_reg(CFG_COLUMNS, 8'd100);
    write_reg(CFG_ROWS, 8'd37);
    write_reg(CFG_ATTR, 8'h1E);
    random_phase(60, 8, 0);
    wait_drained();

    repeat (200) @(negedge clk);
    $display("run covered %0d items (%0d reads, %0d scrolls, %0d newlines), %0d results",
             items_sent, reads_sent, scrolls_sent, newlines_sent, results_seen);
    $display("settings swept from 40 to 128 columns and 10 to 64 rows, with clamping");
    if (errors == 0 && results_q.size() == 0) begin
      $display("[text_console_scrollback] OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, results_q.size());
      $display("[text_console_scrollback] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
